FILE: hw/rtl/speech_endpoint_trimmer_core_assert.svh
// ----------------------------------------------------------------------------
// Speech endpoint trimmer assertion macros
// Short forms for the concurrent checks that the trimmer modules carry.
// ----------------------------------------------------------------------------
`ifndef SPEECH_ENDPOINT_TRIMMER_CORE_ASSERT_SVH
`define SPEECH_ENDPOINT_TRIMMER_CORE_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define SPET_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("trimmer invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SPET_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trimmer implication violated");

// The consequent holds in the cycle after the antecedent.
`define SPET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trimmer sequence violated");

`endif

FILE: hw/rtl/spet_pkg.sv
// ----------------------------------------------------------------------------
// Speech endpoint trimmer package
// Shared types, register codes and constants of the trimmer.
// ----------------------------------------------------------------------------
package spet_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [5:0] MAX_RESULTS     = 6'd48;
    localparam logic [5:0] SPEECH_RUN_MAX  = 6'd63;
    localparam logic [6:0] SILENCE_RUN_MAX = 7'd127;

    localparam logic [3:0] LEADER_RST  = 4'd5;
    localparam logic [3:0] TRAILER_RST = 4'd5;
    localparam logic [4:0] START_RST   = 5'd20;
    localparam logic [5:0] END_RST     = 6'd50;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER  = 2'd0,
        CFG_TRAILER = 2'd1,
        CFG_START   = 2'd2,
        CFG_END     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0] leader_frames;
        logic [3:0] trailer_frames;
        logic [4:0] start_count;
        logic [5:0] end_count;
    } t_cfg;

    typedef struct packed {
        logic [15:0] frame_tag;
        logic        is_speech;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_tag;
        logic        end_of_speech;
    } t_out_item;

    // Command from the classifier to the queue engine.
    typedef struct packed {
        logic [15:0] tag;
        logic        do_push;
        logic        started_before;
        logic        end_hit;
        logic        started_after;
        logic        ended_after;
    } t_cmd;

endpackage

FILE: hw/rtl/spet_front.sv
// ----------------------------------------------------------------------------
// Speech endpoint trimmer front end
// Counts speech and silence runs, tracks onset and end of speech, and turns
// each input transaction into a command for the queue engine.
// ----------------------------------------------------------------------------
module spet_front
    import spet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    logic [5:0] r_speech_run;
    logic [6:0] r_silence_run;
    logic       r_started;
    logic       r_ended;

    logic [5:0] n_speech_run;
    logic [6:0] n_silence_run;
    logic       end_hit;
    logic       started_after;

    always_comb begin
        n_speech_run  = r_speech_run;
        n_silence_run = r_silence_run;
        if (!r_ended) begin
            if (i_item.is_speech) begin
                n_silence_run = '0;
                if (r_speech_run != SPEECH_RUN_MAX) begin
                    n_speech_run = r_speech_run + 6'd1;
                end
            end else begin
                n_speech_run = '0;
                if (r_silence_run != SILENCE_RUN_MAX) begin
                    n_silence_run = r_silence_run + 7'd1;
                end
            end
        end
    end

    assign end_hit       = !r_ended && r_started && (n_silence_run == {1'b0, i_cfg.end_count});
    assign started_after = r_started || (n_speech_run > {1'b0, i_cfg.start_count});

    always_comb begin
        o_cmd.tag            = i_item.frame_tag;
        o_cmd.do_push        = !r_ended;
        o_cmd.started_before = r_started;
        o_cmd.end_hit        = end_hit;
        o_cmd.started_after  = started_after;
        o_cmd.ended_after    = r_ended || end_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speech_run  <= '0;
            r_silence_run <= '0;
            r_started     <= 1'b0;
            r_ended       <= 1'b0;
        end else if (i_accept) begin
            r_speech_run  <= n_speech_run;
            r_silence_run <= n_silence_run;
            r_started     <= started_after;
            r_ended       <= r_ended || end_hit;
        end
    end

endmodule

FILE: hw/rtl/spet_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Speech endpoint trimmer command queue
// Two-entry queue that decouples the front end from the queue engine.
// ----------------------------------------------------------------------------
module spet_cmd_fifo
    import spet_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_data[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/spet_back.sv
// ----------------------------------------------------------------------------
// Speech endpoint trimmer queue engine
// Holds the tag ring, applies the pre-onset window and the end-of-speech
// cut, and releases tags one at a time into the output register.
// ----------------------------------------------------------------------------
`include "speech_endpoint_trimmer_core_assert.svh"

module spet_back
    import spet_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output t_out_item o_result,
    output logic      o_result_valid,
    input  logic      i_result_pop
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = FW + 1;
    localparam int XW = (FW > 7) ? FW : 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRIM,
        S_FETCH,
        S_EMIT
    } t_state;

    logic [15:0] r_mem [QUEUE_DEPTH];
    logic [15:0] r_rd_data;

    t_state      r_state;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [5:0]  r_emit_cnt;
    logic        r_do_push;
    logic        r_started_before;
    logic        r_end_hit;
    logic        r_started;
    logic        r_ended;
    t_out_item   r_out;
    logic        r_out_valid;

    logic [SW-1:0] wr_sum;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [AW-1:0] head_inc;
    logic [XW-1:0] fill_x;
    logic [XW-1:0] win;
    logic [XW-1:0] win_cap;
    logic [XW-1:0] over;
    logic [XW-1:0] head_adv;
    logic [AW-1:0] head_trim;
    logic [5:0]    cut;
    logic [XW-1:0] keep;
    logic          drain_ok;
    logic          emit_load;
    logic          eos;

    // Write slot behind the newest tag; when the ring is full it is the head.
    assign wr_sum  = SW'(r_head) + SW'(r_fill);
    assign wr_addr = (wr_sum >= SW'(QUEUE_DEPTH)) ? AW'(wr_sum - SW'(QUEUE_DEPTH))
                                                   : AW'(wr_sum);
    assign wr_en   = (r_state == S_IDLE) && i_cmd_valid && i_cmd.do_push;

    assign head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign fill_x   = XW'(r_fill);
    assign win      = XW'(i_cfg.leader_frames) + XW'(i_cfg.start_count) + XW'(1);
    assign win_cap  = (win > XW'(QUEUE_DEPTH)) ? XW'(QUEUE_DEPTH) : win;
    assign over     = fill_x - win_cap;
    assign head_adv = XW'(r_head) + over;
    assign head_trim = (head_adv >= XW'(QUEUE_DEPTH)) ? AW'(head_adv - XW'(QUEUE_DEPTH))
                                                      : AW'(head_adv);

    assign cut  = i_cfg.end_count - 6'(i_cfg.trailer_frames);
    assign keep = (fill_x > XW'(cut)) ? fill_x - XW'(cut) : '0;

    assign drain_ok = (r_emit_cnt < MAX_RESULTS) && (r_fill != '0) &&
                      (r_ended || (r_started && (fill_x > XW'(i_cfg.end_count))));

    assign emit_load = (r_state == S_EMIT) && (!r_out_valid || i_result_pop);
    assign eos       = r_ended && (r_fill == FW'(1));

    assign o_cmd_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_head           <= '0;
            r_fill           <= '0;
            r_emit_cnt       <= '0;
            r_do_push        <= 1'b0;
            r_started_before <= 1'b0;
            r_end_hit        <= 1'b0;
            r_started        <= 1'b0;
            r_ended          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (emit_load) begin
                r_out       <= '{out_tag: r_rd_data, end_of_speech: eos};
                r_out_valid <= 1'b1;
            end else if (i_result_pop) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_do_push        <= i_cmd.do_push;
                        r_started_before <= i_cmd.started_before;
                        r_end_hit        <= i_cmd.end_hit;
                        r_started        <= i_cmd.started_after;
                        r_ended          <= i_cmd.ended_after;
                        r_emit_cnt       <= '0;
                        if (i_cmd.do_push) begin
                            if (r_fill == FW'(QUEUE_DEPTH)) begin
                                r_head <= head_inc;
                            end else begin
                                r_fill <= r_fill + FW'(1);
                            end
                        end
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    if (r_do_push) begin
                        if (r_started_before) begin
                            if (r_end_hit &&
                                (i_cfg.trailer_frames <= 4'(i_cfg.end_count)) &&
                                (i_cfg.end_count[5:4] == 2'b00 ||
                                 6'(i_cfg.trailer_frames) <= i_cfg.end_count)) begin
                                r_fill <= FW'(keep);
                            end else if (r_end_hit &&
                                         (6'(i_cfg.trailer_frames) <= i_cfg.end_count)) begin
                                r_fill <= FW'(keep);
                            end
                        end else if (fill_x > win_cap) begin
                            r_head <= head_trim;
                            r_fill <= FW'(win_cap);
                        end
                    end
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    // The ring read of the head is captured in this cycle.
                    r_state <= drain_ok ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (emit_load) begin
                        r_head     <= head_inc;
                        r_fill     <= r_fill - FW'(1);
                        r_emit_cnt <= r_emit_cnt + 6'd1;
                        r_state    <= S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SPET_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(QUEUE_DEPTH))
    `SPET_ASSERT_ALWAYS(a_emit_cap, i_clk, i_rst_n, r_emit_cnt <= MAX_RESULTS)
    `SPET_ASSERT_IMPLIES(a_release_after_onset, i_clk, i_rst_n, emit_load, r_started)
    `SPET_ASSERT_NEXT(a_release_shrinks, i_clk, i_rst_n, emit_load,
                      r_out_valid && (r_fill == $past(r_fill) - FW'(1)))
    `SPET_ASSERT_NEXT(a_marker_empties, i_clk, i_rst_n, emit_load && eos, r_fill == '0)

endmodule

FILE: hw/rtl/speech_endpoint_trimmer_core.sv
// ----------------------------------------------------------------------------
// Speech endpoint trimmer core
// Voice activity endpointing with leader and hangover on a stream of frame
// tags.
// ----------------------------------------------------------------------------
// Each input transaction carries one frame tag and its speech flag; the block
// queues the tags, keeps a leader window before speech onset, releases tags
// oldest first once speech has started, and at end of speech flushes the
// trailer with the last tag marked by end_of_speech. Input transactions are
// taken into a two-entry command queue, so push may follow push in
// consecutive cycles until full rises. The queue engine takes each frame
// through its idle, trim and fetch states and each released tag through one
// ring read and one output register load, at most 48 tags per frame; a full
// output register that is not popped holds the engine. Configuration writes
// must be made only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module speech_endpoint_trimmer_core
    import spet_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd fifo_cmd;
    logic accept;
    logic fifo_valid;
    logic fifo_pop;
    logic result_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_frames  <= LEADER_RST;
            r_cfg.trailer_frames <= TRAILER_RST;
            r_cfg.start_count    <= START_RST;
            r_cfg.end_count      <= END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEADER:  r_cfg.leader_frames  <= i_cfg_data[3:0];
                CFG_TRAILER: r_cfg.trailer_frames <= i_cfg_data[3:0];
                CFG_START:   r_cfg.start_count    <= i_cfg_data[4:0];
                CFG_END:     r_cfg.end_count      <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;
    assign empty  = !result_valid;

    spet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (i_item),
        .o_cmd    (front_cmd)
    );

    spet_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (fifo_valid),
        .i_pop   (fifo_pop),
        .o_cmd   (fifo_cmd)
    );

    spet_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (fifo_valid),
        .i_cmd          (fifo_cmd),
        .o_cmd_pop      (fifo_pop),
        .o_result       (o_result),
        .o_result_valid (result_valid),
        .i_result_pop   (pop)
    );

endmodule
